### design/skut_pkg.sv
// Shared types and constants for the session key table upsert block.
// Used by skut_cell, skut_judge and session_key_table_upsert_core.
`default_nettype none

package skut_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int SLOT_WIDTH          = 6;

   localparam logic [1:0] OUTCOME_APPENDED = 2'd0;
   localparam logic [1:0] OUTCOME_REPLACED = 2'd1;
   localparam logic [1:0] OUTCOME_KEPT     = 2'd2;
   localparam logic [1:0] OUTCOME_FULL     = 2'd3;

   // One session entry; also the request payload.
   typedef struct packed {
      logic [15:0] host_id;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [63:0] stamp_seconds;
      logic [19:0] stamp_micros;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            outcome;
      logic [SLOT_WIDTH-1:0] slot;
   } rsp_payload_type;

   // Verdict on the stored entry currently at the tail of the ring.
   typedef struct packed {
      logic host_match;
      logic take_offer;
   } verdict_type;

endpackage

`default_nettype wire

### design/skut_cell.sv
// One storage cell of the table ring: holds a single session entry.
// Depends on skut_pkg for the entry type.
`default_nettype none

module skut_cell (
   input  wire                         clock,
   input  wire                         shift_en,
   input  skut_pkg::req_payload_type   entry_in,
   output skut_pkg::req_payload_type   entry_out
);

   skut_pkg::req_payload_type entry_ff;

   // Payload only, so no reset: a slot is read only after it was written.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

### design/skut_judge.sv
// Compares an offered entry against a stored one: host match, then
// timestamp order with the key as tie breaker. Depends on skut_pkg.
`default_nettype none

module skut_judge (
   input  skut_pkg::req_payload_type offer,
   input  skut_pkg::req_payload_type stored,
   output skut_pkg::verdict_type     verdict
);

   logic sec_gt;
   logic sec_eq;
   logic us_gt;
   logic us_eq;
   logic key_lt;

   always_comb begin
      sec_gt = offer.stamp_seconds > stored.stamp_seconds;
      sec_eq = offer.stamp_seconds == stored.stamp_seconds;
      us_gt  = offer.stamp_micros > stored.stamp_micros;
      us_eq  = offer.stamp_micros == stored.stamp_micros;
      key_lt = {offer.key_high, offer.key_low} < {stored.key_high, stored.key_low};

      verdict.host_match = offer.host_id == stored.host_id;
      // A newer offer wins; on a tie the smaller key wins.
      verdict.take_offer = sec_gt || (sec_eq && us_gt) || (sec_eq && us_eq && key_lt);
   end

endmodule

`default_nettype wire

### design/session_key_table_upsert_core.sv
// Session key table with insert-or-update, built as a ring of entry cells.
// Depends on skut_pkg, skut_cell and skut_judge.
`default_nettype none

// The table lives in a ring of TABLE_DEPTH cells. For each request transaction
// the ring rotates one full turn, one slot per cycle, and every stored entry
// passes the compare logic at the tail in slot order. The first entry with the
// same host id is kept or overwritten as it passes; with no match, the offer is
// written into the first free slot, or the table reports full with slot 0.
// A transaction is captured, then makes one full rotation of the ring, then its
// result is loaded into the output register (waiting while that still holds an
// unread result); only then can the next one be accepted.
// The result sits in an output register, so a new request transaction is
// accepted while the previous result waits for rsp_ready. Slot numbers are
// reported modulo 64.

module session_key_table_upsert_core #(
   parameter int TABLE_DEPTH = skut_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  skut_pkg::req_payload_type   req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output skut_pkg::rsp_payload_type   rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   skut_pkg::req_payload_type  offer_ff;
   logic [CW-1:0]              step_ff;
   logic [CW-1:0]              count_ff;
   logic                       found_ff;
   logic [1:0]                 outcome_ff;
   logic [CW-1:0]              slot_ff;
   logic                       rsp_valid_ff;
   skut_pkg::rsp_payload_type  rsp_data_ff;

   skut_pkg::req_payload_type  chain [TABLE_DEPTH];
   skut_pkg::req_payload_type  head_in;
   skut_pkg::req_payload_type  tail;
   skut_pkg::verdict_type      verdict;

   logic shift_en;
   logic slot_used;
   logic hit;
   logic append_now;
   logic last_step;
   logic rsp_free;

   assign tail = chain[TABLE_DEPTH-1];

   skut_judge u_judge (
      .offer   (offer_ff),
      .stored  (tail),
      .verdict (verdict)
   );

   genvar j;
   generate
      for (j = 0; j < TABLE_DEPTH; j++) begin : g_cell
         if (j == 0) begin : g_head
            skut_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .entry_in  (head_in),
               .entry_out (chain[j])
            );
         end else begin : g_body
            skut_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .entry_in  (chain[j-1]),
               .entry_out (chain[j])
            );
         end
      end
   endgenerate

   always_comb begin
      shift_en   = state_ff == ST_SEARCH;
      slot_used  = step_ff < count_ff;
      hit        = shift_en && slot_used && verdict.host_match && !found_ff;
      // All used slots have passed by the time the first free slot reaches the tail.
      append_now = shift_en && !found_ff && (step_ff == count_ff);
      last_step  = step_ff == CW'(TABLE_DEPTH - 1);
      head_in    = ((hit && verdict.take_offer) || append_now) ? offer_ff : tail;
      rsp_free   = !rsp_valid_ff || rsp_ready;
      req_ready  = state_ff == ST_IDLE;
      rsp_valid  = rsp_valid_ff;
      rsp_data   = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the finish state a free output register is refilled below instead.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  offer_ff   <= req_data;
                  step_ff    <= '0;
                  found_ff   <= 1'b0;
                  outcome_ff <= skut_pkg::OUTCOME_FULL;
                  slot_ff    <= '0;
                  state_ff   <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (hit) begin
                  found_ff   <= 1'b1;
                  slot_ff    <= step_ff;
                  outcome_ff <= verdict.take_offer ? skut_pkg::OUTCOME_REPLACED
                                                   : skut_pkg::OUTCOME_KEPT;
               end else if (append_now) begin
                  found_ff   <= 1'b1;
                  slot_ff    <= step_ff;
                  outcome_ff <= skut_pkg::OUTCOME_APPENDED;
                  count_ff   <= count_ff + 1'b1;
               end
               if (last_step) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_data_ff.outcome <= outcome_ff;
                  rsp_data_ff.slot    <= skut_pkg::SLOT_WIDTH'(slot_ff);
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for session_key_table_upsert_core: directed and random offers
// are checked against a behavioral copy of the session table, with random idling on both sides.
// Depends on skut_pkg and the session_key_table_upsert_core RTL.

module tb_top;

   localparam int TABLE_SLOTS    = skut_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_OFFERS  = 900;
   localparam int HOST_POOL_SIZE = 80;
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct {
      skut_pkg::req_payload_type offer;
      int unsigned               idle;
      bit                        drain;
   } pending_offer_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   skut_pkg::req_payload_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   skut_pkg::rsp_payload_type rsp_data;

   pending_offer_type         pending_offers[$];
   skut_pkg::rsp_payload_type expected_verdicts[$];
   skut_pkg::req_payload_type shadow_entry[TABLE_SLOTS];
   int unsigned       shadow_fill     = 0;
   int unsigned       offers_planned  = 0;
   int unsigned       offers_accepted = 0;
   int unsigned       error_count     = 0;
   int unsigned       cycle_count     = 0;
   int unsigned       rsp_hold        = 0;
   bit                sender_calm     = 1'b0;
   bit                receiver_calm   = 1'b0;
   bit                req_fire        = 1'b0;
   bit                rsp_fire        = 1'b0;
   bit                rsp_stalled     = 1'b0;

   session_key_table_upsert_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Applies one offer to the shadow table and returns the verdict the block must give.
   function automatic skut_pkg::rsp_payload_type predict_upsert(
         input skut_pkg::req_payload_type offer);
      skut_pkg::rsp_payload_type verdict;
      logic [83:0]     offer_stamp;
      logic [83:0]     held_stamp;
      bit              take_offer;
      verdict.outcome = skut_pkg::OUTCOME_FULL;
      verdict.slot    = '0;
      offer_stamp     = {offer.stamp_seconds, offer.stamp_micros};
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_entry[i].host_id == offer.host_id) begin
            held_stamp = {shadow_entry[i].stamp_seconds, shadow_entry[i].stamp_micros};
            if (offer_stamp != held_stamp) begin
               take_offer = offer_stamp > held_stamp;
            end else begin
               take_offer = {offer.key_high, offer.key_low} <
                            {shadow_entry[i].key_high, shadow_entry[i].key_low};
            end
            if (take_offer) begin
               shadow_entry[i] = offer;
            end
            verdict.outcome = take_offer ? skut_pkg::OUTCOME_REPLACED
                                         : skut_pkg::OUTCOME_KEPT;
            verdict.slot    = i[skut_pkg::SLOT_WIDTH-1:0];
            return verdict;
         end
      end
      if (shadow_fill < TABLE_SLOTS) begin
         shadow_entry[shadow_fill] = offer;
         verdict.outcome           = skut_pkg::OUTCOME_APPENDED;
         verdict.slot              = shadow_fill[skut_pkg::SLOT_WIDTH-1:0];
         shadow_fill++;
      end
      return verdict;
   endfunction

   function automatic skut_pkg::req_payload_type make_entry(input logic [15:0] host,
                                                            input logic [63:0] key_hi,
                                                            input logic [63:0] key_lo,
                                                            input logic [63:0] seconds,
                                                            input logic [19:0] micros);
      skut_pkg::req_payload_type entry;
      entry.host_id       = host;
      entry.key_high      = key_hi;
      entry.key_low       = key_lo;
      entry.stamp_seconds = seconds;
      entry.stamp_micros  = micros;
      return entry;
   endfunction

   function automatic skut_pkg::req_payload_type fresh_offer(input logic [15:0] host);
      logic [63:0] seconds;
      logic [19:0] micros;
      case ($urandom_range(0, 3))
         0: seconds = 64'($urandom_range(0, 15));
         1: seconds = ~64'($urandom_range(0, 15));
         default: seconds = {$urandom, $urandom};
      endcase
      // Now and then the microseconds go past the legal range.
      if ($urandom_range(0, 9) == 0) begin
         micros = 20'($urandom_range(999990, 20'hFFFFF));
      end else begin
         micros = 20'($urandom_range(0, 999999));
      end
      return make_entry(host, {$urandom, $urandom}, {$urandom, $urandom}, seconds, micros);
   endfunction

   task automatic queue_offer(input skut_pkg::req_payload_type offer, input bit drain);
      pending_offer_type pending;
      if ($urandom_range(0, 39) == 0) begin
         sender_calm = !sender_calm;
      end
      pending.offer = offer;
      pending.idle  = sender_calm ? 0 : $urandom_range(0, 9);
      pending.drain = drain;
      pending_offers.push_back(pending);
      offers_planned++;
   endtask

   initial begin : stimulus
      logic [15:0]               host_pool[HOST_POOL_SIZE];
      skut_pkg::req_payload_type last_offer[bit [15:0]];
      skut_pkg::req_payload_type offer;
      logic [127:0]              key;
      logic [15:0]               host;
      logic [63:0]               ones;

      ones = '1;
      for (int i = 0; i < HOST_POOL_SIZE; i++) begin
         host_pool[i] = 16'($urandom);
      end

      // Field extremes, the timestamp and key ordering rules, and raw micros compares.
      queue_offer(make_entry(16'h0000, 64'd0, 64'd0, 64'd0, 20'd0), 1'b0);
      queue_offer(make_entry(16'hFFFF, ones, ones, ones, 20'd999999), 1'b0);
      queue_offer(make_entry(16'h0000, 64'd0, 64'd0, 64'd0, 20'd0), 1'b0);
      queue_offer(make_entry(16'hFFFF, ones, ones - 64'd1, ones, 20'd999999), 1'b0);
      queue_offer(make_entry(16'hFFFF, ones, ones, ones, 20'd999999), 1'b0);
      queue_offer(make_entry(16'h0000, ones, ones, 64'd0, 20'd1), 1'b0);
      queue_offer(make_entry(16'h0000, 64'd0, 64'd0, 64'd0, 20'd0), 1'b0);
      queue_offer(make_entry(16'h0000, 64'd0, 64'd0, 64'd1, 20'd0), 1'b0);
      queue_offer(make_entry(16'h0000, ones, 64'd0, 64'd0, 20'hFFFFF), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd5, 64'd0, 64'd5, 20'hFFFFF), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd0, 64'd0, 64'd5, 20'd999999), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd5, 64'd0, 64'd6, 20'd0), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd4, ones, 64'd6, 20'd0), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd4, 64'd0, 64'd6, 20'd0), 1'b0);
      queue_offer(make_entry(16'h1234, 64'd4, 64'd0, 64'd6, 20'd0), 1'b0);
      queue_offer(make_entry(16'hFFFF, 64'd0, 64'd0, ones - 64'd1, 20'd999999), 1'b0);

      // Mostly revisits of a host pool larger than the table, so the table fills
      // and keeps seeing matches; the rest are stray hosts.
      for (int n = 0; n < RANDOM_OFFERS; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            host = 16'($urandom);
         end else begin
            host = host_pool[$urandom_range(0, HOST_POOL_SIZE - 1)];
         end
         if (last_offer.exists(host) && $urandom_range(0, 3) != 0) begin
            offer = last_offer[host];
            key   = {offer.key_high, offer.key_low};
            case ($urandom_range(0, 5))
               0: ;
               1: key = key - 128'd1;
               2: key = key + 128'd1;
               3: offer.stamp_micros = offer.stamp_micros +
                                       ($urandom_range(0, 1) ? 20'd1 : 20'hFFFFF);
               4: offer.stamp_seconds = offer.stamp_seconds +
                                        ($urandom_range(0, 1) ? 64'd1 : ones);
               default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            {offer.key_high, offer.key_low} = key;
         end else begin
            offer = fresh_offer(host);
         end
         last_offer[host] = offer;
         queue_offer(offer, n == 0 || $urandom_range(0, 149) == 0);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (offers_accepted < offers_planned || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (TABLE_SLOTS + 8) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(negedge clock) begin : offer_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_offers.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_offers[0].idle != 0) begin
            pending_offers[0].idle = pending_offers[0].idle - 1;
            req_valid <= 1'b0;
         end else if (pending_offers[0].drain && expected_verdicts.size() != 0) begin
            // Hold off until the block has returned every outstanding result.
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_offers[0].offer;
            req_valid <= 1'b1;
            void'(pending_offers.pop_front());
         end
      end
   end

   // A drawn stall only counts down while a result is actually waiting.
   always @(negedge clock) begin : result_sink
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 9);
      end else if (rsp_fire) begin
         if ($urandom_range(0, 49) == 0) begin
            receiver_calm = !receiver_calm;
         end
         hold = receiver_calm ? 0 : $urandom_range(0, 9);
         rsp_hold  <= hold;
         rsp_ready <= (hold == 0);
      end else if (rsp_hold == 0) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stalled) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end
   end

   always @(posedge clock) begin : monitor
      skut_pkg::rsp_payload_type due;
      if (reset) begin
         req_fire    <= 1'b0;
         rsp_fire    <= 1'b0;
         rsp_stalled <= 1'b0;
      end else begin
         req_fire    <= req_valid && req_ready;
         rsp_fire    <= rsp_valid && rsp_ready;
         rsp_stalled <= rsp_valid && !rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("result transaction with none pending: outcome %0d, slot %0d",
                      rsp_data.outcome, rsp_data.slot);
               error_count++;
            end else begin
               due = expected_verdicts.pop_front();
               if (rsp_data.outcome !== due.outcome) begin
                  $error("outcome: expected %0d, actual %0d", due.outcome, rsp_data.outcome);
                  error_count++;
               end
               if (rsp_data.slot !== due.slot) begin
                  $error("slot: expected %0d, actual %0d", due.slot, rsp_data.slot);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(predict_upsert(req_data));
            offers_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
